[src/bfa_pkg.sv]
package bfa_pkg;

	localparam int OWNER_W  = 8;
	localparam int LENGTH_W = 11;
	localparam int STATUS_W = 2;
	localparam int START_W  = 10;

	localparam logic ACT_ALLOCATE = 1'b0;
	localparam logic ACT_RELEASE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FAILED    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RELEASED  = 2'd2;

	typedef struct packed {
		logic                action;
		logic [OWNER_W-1:0]  owner_id;
		logic [LENGTH_W-1:0] request_length;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [START_W-1:0]  block_start;
	} rsp_t;

	typedef struct packed {
		logic               held;
		logic [OWNER_W-1:0] owner;
	} cell_t;

endpackage

[src/best_fit_block_allocator.sv]
// Best-fit allocator over a map of NUM_CELLS cells held in one synchronous RAM. After reset the
// block runs a clearing pass over every cell with busy high before it takes its first request.
// A request is taken when start is high and busy is low. An allocate request with zero length
// fails without reading the map. Any other allocate reads the whole map once, one cell a cycle
// through the single RAM read port, and then writes the chosen run one cell a cycle; on failure
// nothing is written. A release request reads and checks every cell and writes back as free the
// cells held by its owner_id. The result appears on result for exactly one cycle with done high;
// the receiver cannot stall it and must take it then.
module best_fit_block_allocator #(
	parameter int NUM_CELLS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bfa_pkg::req_t request,
	output logic          done,
	output bfa_pkg::rsp_t result
);

	localparam int AW = $clog2(NUM_CELLS);
	localparam int CW = (AW + 1 > bfa_pkg::LENGTH_W) ? AW + 1 : bfa_pkg::LENGTH_W;
	localparam int SW = (AW > bfa_pkg::START_W) ? AW : bfa_pkg::START_W;
	localparam logic [AW:0]   CELLS     = (AW + 1)'(NUM_CELLS);
	localparam logic [AW-1:0] LAST_CELL = AW'(NUM_CELLS - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_EVAL,
		S_FILL,
		S_RELEASE
	} state_t;

	state_t                      state_q;
	logic [AW:0]                 addr_q;
	logic [CW-1:0]               cnt_q;
	logic [CW-1:0]               want_q;
	logic [bfa_pkg::OWNER_W-1:0] owner_q;
	logic [AW-1:0]               run_start_q;
	logic [CW-1:0]               run_len_q;
	logic [AW-1:0]               best_start_q;
	logic [CW-1:0]               best_len_q;
	logic                        found_q;
	logic                        vld_s1;
	logic [AW-1:0]               idx_s1;
	logic                        done_q;
	bfa_pkg::rsp_t               result_q;

	bfa_pkg::cell_t mem [NUM_CELLS];
	bfa_pkg::cell_t rd_data_s1;
	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	bfa_pkg::cell_t mem_wdata;
	logic [AW-1:0]  mem_raddr;

	logic           close_ok;
	logic           found_n;
	logic [AW-1:0]  pick_start;
	logic [SW-1:0]  start_wide;
	logic           rd_more;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[mem_raddr];
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q[AW-1:0];
		mem_wdata = '0;
		mem_raddr = addr_q[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_FILL: begin
				mem_we         = 1'b1;
				mem_wdata.held  = 1'b1;
				mem_wdata.owner = owner_q;
			end
			S_RELEASE: begin
				// Reads run one cell ahead of the write-back, so they never touch the same cell.
				mem_we    = vld_s1 && rd_data_s1.held && (rd_data_s1.owner == owner_q);
				mem_waddr = idx_s1;
			end
			default: begin
			end
		endcase
	end

	// A run closes when a held cell or the end of the map follows it.
	assign close_ok   = (run_len_q >= want_q) && (!found_q || (run_len_q < best_len_q));
	assign found_n    = found_q || close_ok;
	assign pick_start = close_ok ? run_start_q : best_start_q;
	assign start_wide = SW'(best_start_q);
	assign rd_more    = addr_q < CELLS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			addr_q       <= '0;
			cnt_q        <= '0;
			want_q       <= '0;
			owner_q      <= '0;
			run_start_q  <= '0;
			run_len_q    <= '0;
			best_start_q <= '0;
			best_len_q   <= '0;
			found_q      <= 1'b0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			done_q       <= 1'b0;
			result_q     <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q[AW-1:0] == LAST_CELL) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						addr_q      <= '0;
						owner_q     <= request.owner_id;
						want_q      <= CW'(request.request_length);
						run_len_q   <= '0;
						run_start_q <= '0;
						best_len_q  <= '0;
						best_start_q <= '0;
						found_q     <= 1'b0;
						if (request.action == bfa_pkg::ACT_RELEASE) begin
							state_q <= S_RELEASE;
						end else if (request.request_length == '0) begin
							done_q               <= 1'b1;
							result_q.status      <= bfa_pkg::ST_FAILED;
							result_q.block_start <= '0;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rd_more) begin
						addr_q <= addr_q + 1'b1;
						vld_s1 <= 1'b1;
						idx_s1 <= addr_q[AW-1:0];
					end
					if (vld_s1) begin
						if (!rd_data_s1.held) begin
							if (run_len_q == '0) begin
								run_start_q <= idx_s1;
							end
							run_len_q <= run_len_q + 1'b1;
						end else begin
							found_q      <= found_n;
							best_start_q <= pick_start;
							if (close_ok) begin
								best_len_q <= run_len_q;
							end
							run_len_q <= '0;
						end
						if (idx_s1 == LAST_CELL) begin
							state_q <= S_EVAL;
						end
					end
				end
				S_EVAL: begin
					best_start_q <= pick_start;
					if (found_n) begin
						addr_q  <= (AW + 1)'(pick_start);
						cnt_q   <= want_q;
						state_q <= S_FILL;
					end else begin
						done_q               <= 1'b1;
						result_q.status      <= bfa_pkg::ST_FAILED;
						result_q.block_start <= '0;
						state_q              <= S_IDLE;
					end
				end
				S_FILL: begin
					addr_q <= addr_q + 1'b1;
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						done_q               <= 1'b1;
						result_q.status      <= bfa_pkg::ST_ALLOCATED;
						result_q.block_start <= start_wide[bfa_pkg::START_W-1:0];
						state_q              <= S_IDLE;
					end
				end
				S_RELEASE: begin
					if (rd_more) begin
						addr_q <= addr_q + 1'b1;
						vld_s1 <= 1'b1;
						idx_s1 <= addr_q[AW-1:0];
					end
					if (vld_s1 && (idx_s1 == LAST_CELL)) begin
						done_q               <= 1'b1;
						result_q.status      <= bfa_pkg::ST_RELEASED;
						result_q.block_start <= '0;
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

[tb/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CELLS    = 1024;
	localparam int RANDOM_ITEMS = 266;
	localparam int POOL_SIZE    = 8;
	localparam int DIR_ROWS     = 24;

	typedef struct packed {
		bfa_pkg::req_t req;
		logic          fixed;
		bfa_pkg::rsp_t rsp;
	} dir_row_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic          done;
	bfa_pkg::req_t request;
	bfa_pkg::rsp_t result;

	bfa_pkg::cell_t              shadow_map [NUM_CELLS];
	bfa_pkg::rsp_t               pending_outcomes [$];
	int                          mismatch_count;
	logic [bfa_pkg::OWNER_W-1:0] owner_pool [POOL_SIZE];

	// Rows with fixed set carry an outcome that is plain from the map contents at that point.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{'{bfa_pkg::ACT_ALLOCATE, 8'h00, 11'd0},    1'b1, '{bfa_pkg::ST_FAILED,    10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'hFF, 11'd1},    1'b1, '{bfa_pkg::ST_ALLOCATED, 10'd0}},
		'{'{bfa_pkg::ACT_RELEASE,  8'hFF, 11'd0},    1'b1, '{bfa_pkg::ST_RELEASED,  10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'h00, 11'd1024}, 1'b1, '{bfa_pkg::ST_ALLOCATED, 10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'h01, 11'd1},    1'b1, '{bfa_pkg::ST_FAILED,    10'd0}},
		'{'{bfa_pkg::ACT_RELEASE,  8'h00, 11'h7FF},  1'b1, '{bfa_pkg::ST_RELEASED,  10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'h5A, 11'd1025}, 1'b1, '{bfa_pkg::ST_FAILED,    10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'hA5, 11'd2047}, 1'b1, '{bfa_pkg::ST_FAILED,    10'd0}},
		'{'{bfa_pkg::ACT_RELEASE,  8'h55, 11'd0},    1'b1, '{bfa_pkg::ST_RELEASED,  10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'hAA, 11'd100},  1'b1, '{bfa_pkg::ST_ALLOCATED, 10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'h55, 11'd200},  1'b0, '{bfa_pkg::ST_FAILED,    10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'h0F, 11'd50},   1'b0, '{bfa_pkg::ST_FAILED,    10'd0}},
		'{'{bfa_pkg::ACT_RELEASE,  8'h55, 11'd3},    1'b1, '{bfa_pkg::ST_RELEASED,  10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'hF0, 11'd150},  1'b0, '{bfa_pkg::ST_FAILED,    10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'h33, 11'd60},   1'b0, '{bfa_pkg::ST_FAILED,    10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'hC3, 11'd600},  1'b0, '{bfa_pkg::ST_FAILED,    10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'h3C, 11'd100},  1'b0, '{bfa_pkg::ST_FAILED,    10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'h81, 11'd14},   1'b0, '{bfa_pkg::ST_FAILED,    10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'h00, 11'd5},    1'b0, '{bfa_pkg::ST_FAILED,    10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'h7E, 11'd45},   1'b0, '{bfa_pkg::ST_FAILED,    10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'h42, 11'd1},    1'b0, '{bfa_pkg::ST_FAILED,    10'd0}},
		'{'{bfa_pkg::ACT_RELEASE,  8'h0F, 11'd0},    1'b1, '{bfa_pkg::ST_RELEASED,  10'd0}},
		'{'{bfa_pkg::ACT_RELEASE,  8'h81, 11'd0},    1'b1, '{bfa_pkg::ST_RELEASED,  10'd0}},
		'{'{bfa_pkg::ACT_ALLOCATE, 8'h18, 11'd10},   1'b0, '{bfa_pkg::ST_FAILED,    10'd0}}
	};

	best_fit_block_allocator #(.NUM_CELLS(NUM_CELLS)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always #5 clk = ~clk;

	// Applies one request to the shadow map and returns the outcome the block must report.
	function automatic bfa_pkg::rsp_t best_fit_predict(bfa_pkg::req_t r);
		bfa_pkg::rsp_t o;
		logic found;
		logic is_free;
		int   best_start;
		int   best_len;
		int   run_start;
		int   run_len;
		o.status      = bfa_pkg::ST_RELEASED;
		o.block_start = '0;
		if (r.action == bfa_pkg::ACT_RELEASE) begin
			foreach (shadow_map[i])
				if (shadow_map[i].held && shadow_map[i].owner == r.owner_id)
					shadow_map[i] = '0;
			return o;
		end
		o.status = bfa_pkg::ST_FAILED;
		if (r.request_length == 0)
			return o;
		found      = 1'b0;
		best_start = 0;
		best_len   = 0;
		run_start  = 0;
		run_len    = 0;
		// One step past the last cell closes a run that reaches the end of the map.
		for (int i = 0; i <= NUM_CELLS; i++) begin
			is_free = (i < NUM_CELLS) ? !shadow_map[i].held : 1'b0;
			if (is_free) begin
				if (run_len == 0)
					run_start = i;
				run_len++;
			end else begin
				if (run_len >= int'(r.request_length) && (!found || run_len < best_len)) begin
					found      = 1'b1;
					best_len   = run_len;
					best_start = run_start;
				end
				run_len = 0;
			end
		end
		if (!found)
			return o;
		for (int i = best_start; i < best_start + int'(r.request_length); i++)
			shadow_map[i] = '{held: 1'b1, owner: r.owner_id};
		o.status      = bfa_pkg::ST_ALLOCATED;
		o.block_start = best_start[bfa_pkg::START_W-1:0];
		return o;
	endfunction

	function automatic bfa_pkg::req_t random_request();
		bfa_pkg::req_t r;
		int            pick;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 4) == 0)
			r.owner_id = 8'($urandom_range(0, 255));
		else
			r.owner_id = owner_pool[$urandom_range(0, POOL_SIZE-1)];
		r.action = bfa_pkg::ACT_ALLOCATE;
		if (pick < 36) begin
			r.action         = bfa_pkg::ACT_RELEASE;
			r.request_length = 11'($urandom_range(0, 2047));
		end else if (pick < 40) begin
			r.request_length = $urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(1025, 2047));
		end else if (pick < 80) begin
			r.request_length = 11'($urandom_range(1, 32));
		end else if (pick < 95) begin
			r.request_length = 11'($urandom_range(33, 300));
		end else begin
			r.request_length = 11'($urandom_range(301, 1024));
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 4);
		// Long enough at times to let the block go idle before the next request.
		return $urandom_range(20, 2600);
	endfunction

	task automatic send_request(bfa_pkg::req_t r, logic fixed, bfa_pkg::rsp_t typed, logic drain);
		int            gap;
		bfa_pkg::rsp_t outcome;
		gap = pick_gap();
		if (drain && gap == 0)
			gap = 1;
		if (gap > 0) begin
			start   <= 1'b0;
			request <= 20'($urandom_range(0, 1048575));
			if (drain)
				while (pending_outcomes.size() != 0)
					@(negedge clk);
			repeat (gap) @(negedge clk);
		end
		start   <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		outcome = best_fit_predict(r);
		pending_outcomes.push_back(fixed ? typed : outcome);
		@(negedge clk);
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		request        = '0;
		mismatch_count = 0;
		foreach (owner_pool[k])
			owner_pool[k] = 8'($urandom_range(0, 255));
		foreach (shadow_map[k])
			shadow_map[k] = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_rows[k])
			send_request(dir_rows[k].req, dir_rows[k].fixed, dir_rows[k].rsp, 1'b0);
		for (int n = 0; n < RANDOM_ITEMS; n++)
			send_request(random_request(), 1'b0, '0,
				n == RANDOM_ITEMS / 2 || $urandom_range(0, 49) == 0);
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	always @(posedge clk) begin
		bfa_pkg::rsp_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: result with no request outstanding: status %0d start %0d",
					$time, result.status, result.block_start);
				mismatch_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, result.status);
					mismatch_count++;
				end
				if (result.block_start !== want.block_start) begin
					$display("%0t: block_start expected %0d actual %0d",
						$time, want.block_start, result.block_start);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
